>>> sv/weighted_interleaved_rr_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weighted interleaved round-robin scheduler
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_INTERLEAVED_RR_SCHEDULER_DEFINES_SVH
`define WEIGHTED_INTERLEAVED_RR_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define WIRR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, disabled while reset is held
`define WIRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

>>> sv/wirr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wirr_pkg
// Field widths, operation and register codes, and sequencer states of the
// weighted interleaved round-robin scheduler.
// ----------------------------------------------------------------------------
package wirr_pkg;

    // Payload field widths
    localparam int OP_W       = 1;
    localparam int QIDX_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int WEIGHT_W   = 8;
    localparam int QIU_W      = 3;
    localparam int TOTAL_W    = 4;

    // Finished counter ceiling
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 4'd15;

    // Number of weight registers on the configuration port
    localparam int WEIGHT_REGS = 4;

    // Item operations
    localparam logic [OP_W-1:0] OP_ENQUEUE = 1'b0;
    localparam logic [OP_W-1:0] OP_SELECT  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT1       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT2       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT3       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUES_IN_USE = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_SCAN,
        ST_SPEND,
        ST_SETTLE
    } t_state;

endpackage

>>> sv/wirr_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------

// Item channel: enqueue or select
interface wirr_item_if;
    logic                       valid;
    logic                       ready;
    logic [wirr_pkg::OP_W-1:0]   operation;
    logic [wirr_pkg::QIDX_W-1:0] queue_index;

    modport source (output valid, operation, queue_index, input ready);
    modport sink   (input valid, operation, queue_index, output ready);
endinterface

// Result channel: one beat per select
interface wirr_result_if;
    logic                       valid;
    logic                       ready;
    logic                       served;
    logic [wirr_pkg::QIDX_W-1:0] served_queue;

    modport source (output valid, served, served_queue, input ready);
    modport sink   (input valid, served, served_queue, output ready);
endinterface

// Configuration write channel
interface wirr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [wirr_pkg::CFG_IDX_W-1:0]  index;
    logic [wirr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/weighted_interleaved_rr_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_interleaved_rr_scheduler
// Weighted interleaved round-robin queue scheduler with per-queue backlog
// and credit counters, driven by a small sequencer.
// ----------------------------------------------------------------------------
// An enqueue beat is taken in the idle state and the block stays ready. A
// select beat passes through WRAP, SCAN, SPEND and SETTLE. WRAP repeats a
// subtract step (at most NUM_QUEUES times) that wraps the rotation pointer into
// the active queue count, then sees that the wrap is done; SCAN visits 1 to the
// active count of queues, one per cycle,
// through a single shared step unit; the result is then held in an output
// register, so the next beat is taken while it waits.
// A further select stalls in its last cycle only while the previous result is
// still not taken. Configuration writes are always accepted and are meant
// for when the block is idle.
module weighted_interleaved_rr_scheduler #(
    parameter int NUM_QUEUES   = 4,
    parameter int BACKLOG_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wirr_item_if.sink       i_item,
    wirr_result_if.source   o_result,
    wirr_cfg_if.sink        i_cfg
);
    import wirr_pkg::*;

    localparam int QW = $clog2(NUM_QUEUES);
    localparam int NW = $clog2(NUM_QUEUES + 1);

    // Per-queue state
    logic [BACKLOG_BITS-1:0] r_backlog [NUM_QUEUES];
    logic [WEIGHT_W-1:0]     r_credit  [NUM_QUEUES];
    logic [WEIGHT_W-1:0]     r_weight  [NUM_QUEUES];
    logic [NUM_QUEUES-1:0]   r_fin;

    // Scheduler state
    logic [QW-1:0]      r_ptr;
    logic [TOTAL_W-1:0] r_total;
    logic [QIU_W-1:0]   r_qiu;

    // Sequencer working registers
    t_state        r_state, n_state;
    logic [NW-1:0] r_pos;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_step;
    logic          r_none;

    // Result register
    logic          r_out_valid;
    logic          r_served;
    logic [QIDX_W-1:0] r_served_queue;

    // Control strobes
    logic          in_take;
    logic          enq_take;
    logic          sel_take;
    logic          wrap_sub;
    logic          settle_go;

    // Step unit: wrap subtract, scan advance and active count clamp
    logic [QW-1:0] cur_q;
    logic          cur_elig;
    logic [NW-1:0] pos_inc;
    logic [NW-1:0] pos_next;
    logic [NW-1:0] step_inc;
    logic [NW-1:0] n_clamped;
    logic          reload;
    logic [QW-1:0] enq_q;
    logic          enq_ok;
    logic [QW-1:0] cfg_q;
    logic          cfg_q_ok;
    logic [WEIGHT_W-1:0] cfg_weight;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        sat_inc = (v == TOTAL_MAX) ? v : v + TOTAL_W'(1);
    endfunction

    always_comb begin
        cur_q    = r_pos[QW-1:0];
        cur_elig = (r_backlog[cur_q] != '0) && !r_fin[cur_q];
        pos_inc  = r_pos + NW'(1);
        pos_next = (pos_inc == r_n) ? '0 : pos_inc;
        step_inc = r_step + NW'(1);
        reload   = 32'(r_total) >= 32'(r_n);
        enq_q    = QW'(i_item.queue_index);
        enq_ok   = 32'(i_item.queue_index) < NUM_QUEUES;
        cfg_q    = QW'(i_cfg.index[1:0]);
        cfg_q_ok = 32'(i_cfg.index[1:0]) < NUM_QUEUES;
        cfg_weight = (i_cfg.data == '0) ? WEIGHT_W'(1) : WEIGHT_W'(i_cfg.data);
        if (r_qiu == '0) begin
            n_clamped = NW'(1);
        end else if (32'(r_qiu) > NUM_QUEUES) begin
            n_clamped = NW'(NUM_QUEUES);
        end else begin
            n_clamped = NW'(r_qiu);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item.valid && i_item.operation == OP_SELECT) begin
                    n_state = ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (r_pos < r_n) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cur_elig || step_inc == r_n) begin
                    n_state = ST_SPEND;
                end
            end
            ST_SPEND: begin
                n_state = ST_SETTLE;
            end
            ST_SETTLE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs and strobes
    always_comb begin
        in_take   = (r_state == ST_IDLE) && i_item.valid;
        enq_take  = in_take && (i_item.operation == OP_ENQUEUE);
        sel_take  = in_take && (i_item.operation == OP_SELECT);
        wrap_sub  = (r_state == ST_WRAP) && (r_pos >= r_n);
        settle_go = (r_state == ST_SETTLE) && (!r_out_valid || o_result.ready);
    end

    assign i_item.ready          = (r_state == ST_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_result.valid        = r_out_valid;
    assign o_result.served       = r_served;
    assign o_result.served_queue = r_served_queue;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_n    <= NW'(1);
            r_step <= '0;
            r_none <= 1'b0;
        end else begin
            if (sel_take) begin
                // Start one past the pointer, wrapped below
                r_pos  <= NW'(r_ptr) + NW'(1);
                r_n    <= n_clamped;
                r_step <= '0;
                r_none <= 1'b0;
            end
            if (wrap_sub) begin
                r_pos <= r_pos - r_n;
            end
            if (r_state == ST_SCAN && !cur_elig) begin
                r_pos  <= pos_next;
                r_step <= step_inc;
                if (step_inc == r_n) begin
                    r_none <= 1'b1;
                end
            end
        end
    end

    // Queue state, rotation pointer and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_backlog[q] <= '0;
                r_credit[q]  <= WEIGHT_W'(1);
                r_weight[q]  <= WEIGHT_W'(1);
            end
            r_fin   <= '0;
            r_ptr   <= QW'(NUM_QUEUES - 1);
            r_total <= '0;
            r_qiu   <= QIU_W'(4);
        end else begin
            // Enqueue: bump backlog, hold at full
            if (enq_take && enq_ok && r_backlog[enq_q] != '1) begin
                r_backlog[enq_q] <= r_backlog[enq_q] + BACKLOG_BITS'(1);
            end

            // Scan: mark empty queues finished on the way past
            if (r_state == ST_SCAN && !cur_elig && !r_fin[cur_q]) begin
                r_fin[cur_q] <= 1'b1;
                r_total      <= sat_inc(r_total);
            end

            // Spend one credit of the chosen queue
            if (r_state == ST_SPEND) begin
                r_ptr <= cur_q;
                if (r_credit[cur_q] == WEIGHT_W'(1)) begin
                    r_fin[cur_q] <= 1'b1;
                    r_total      <= sat_inc(r_total);
                end
                if (r_credit[cur_q] != '0) begin
                    r_credit[cur_q] <= r_credit[cur_q] - WEIGHT_W'(1);
                end
            end

            // Settle: reload the round, drop one packet of the served queue
            if (settle_go) begin
                if (reload) begin
                    r_total <= '0;
                    r_fin   <= '0;
                    for (int q = 0; q < NUM_QUEUES; q++) begin
                        r_credit[q] <= r_weight[q];
                    end
                end
                if (!r_none && r_backlog[cur_q] != '0) begin
                    r_backlog[cur_q] <= r_backlog[cur_q] - BACKLOG_BITS'(1);
                end
            end

            // Configuration writes
            if (i_cfg.valid) begin
                unique case (i_cfg.index) inside
                    CFG_WEIGHT0, CFG_WEIGHT1, CFG_WEIGHT2, CFG_WEIGHT3: begin
                        if (cfg_q_ok) begin
                            r_weight[cfg_q] <= cfg_weight;
                            r_credit[cfg_q] <= cfg_weight;
                        end
                    end
                    CFG_QUEUES_IN_USE: begin
                        r_qiu <= QIU_W'(i_cfg.data);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result register: load on settle, drop on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (settle_go) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (settle_go) begin
            r_served       <= !r_none;
            r_served_queue <= r_none ? '0 : QIDX_W'(cur_q);
        end
    end

endmodule

>>> sv/wirr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wirr_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "weighted_interleaved_rr_scheduler_defines.svh"

module wirr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic [wirr_pkg::OP_W-1:0]   i_operation,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_served,
    input logic [wirr_pkg::QIDX_W-1:0] i_served_queue
);
    import wirr_pkg::*;

    logic enq_beat;
    logic sel_beat;

    assign enq_beat = i_in_valid && i_in_ready && (i_operation == OP_ENQUEUE);
    assign sel_beat = i_in_valid && i_in_ready && (i_operation == OP_SELECT);

    // An enqueue finishes in its own cycle
    `WIRR_ASSERT_NEXT(a_enq_single_cycle, i_clk, i_rst_n, enq_beat, i_in_ready)

    // A select holds the block busy in the following cycle
    `WIRR_ASSERT_NEXT(a_sel_busy, i_clk, i_rst_n, sel_beat, !i_in_ready)

    // An empty result names no queue
    `WIRR_ASSERT_NOW(a_none_zero_queue, i_clk, i_rst_n,
        i_out_valid && !i_served, i_served_queue == '0)

    // A waiting result stays offered
    `WIRR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready, i_out_valid)

endmodule

bind weighted_interleaved_rr_scheduler wirr_checker u_wirr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_operation    (i_item.operation),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_served       (o_result.served),
    .i_served_queue (o_result.served_queue)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted interleaved round-robin scheduler testbench
// Drives enqueue and select beats with random gaps and stalls, and programs
// weights and the rotation size between phases while the block is idle. It
// keeps its own copy of backlog, credit and rotation state, and checks every
// grant beat field by field against the oldest predicted grant. The run ends
// by piling packets onto one queue and serving from it.
// ----------------------------------------------------------------------------
module testbench;
    import wirr_pkg::*;

    localparam int NQ           = 4;
    localparam int BL_BITS      = 16;
    localparam int CREDIT_W     = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS  = 115;
    localparam int TAIL_ENQUEUES = 12;

    // Register indexes that the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [QIDX_W-1:0] qidx;
    } sched_item_t;

    typedef struct packed {
        logic              served;
        logic [QIDX_W-1:0] queue;
    } grant_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Channel drive and sample variables
    logic                  item_valid  = 1'b0;
    logic [OP_W-1:0]       item_op     = '0;
    logic [QIDX_W-1:0]     item_qidx   = '0;
    logic                  grant_ready = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    logic item_beat  = 1'b0;
    logic grant_beat = 1'b0;
    logic cfg_beat   = 1'b0;

    int item_gap      = 0;
    int grant_gap     = 0;
    int hold_left     = 0;
    bit pressure_done = 1'b0;
    bit pressure_armed = 1'b0;
    bit gaps_on       = 1'b1;
    int stall_cycles  = 0;
    int error_count   = 0;

    sched_item_t offered_items[$];
    grant_t      expected_grants[$];

    // Scheduler state mirror
    logic [WEIGHT_W-1:0] weight_reg  [NQ];
    logic [QIU_W-1:0]    rotation_cfg;
    logic [BL_BITS-1:0]  backlog_cnt [NQ];
    logic [CREDIT_W-1:0] credit_cnt  [NQ];
    logic                done_flag   [NQ];
    logic [QIDX_W-1:0]   rr_ptr;
    logic [TOTAL_W-1:0]  done_total;

    wirr_item_if   item_ch ();
    wirr_result_if grant_ch ();
    wirr_cfg_if    cfg_ch ();

    assign item_ch.valid       = item_valid;
    assign item_ch.operation   = item_op;
    assign item_ch.queue_index = item_qidx;
    assign grant_ch.ready      = grant_ready;
    assign cfg_ch.valid        = cfg_valid;
    assign cfg_ch.index        = cfg_index;
    assign cfg_ch.data         = cfg_data;

    weighted_interleaved_rr_scheduler uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (grant_ch),
        .i_cfg    (cfg_ch)
    );

    initial begin : clock_gen
        forever #2 i_clk = ~i_clk;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic reset_mirror();
        int q;
        for (q = 0; q < NQ; q++) begin
            weight_reg[q]  = 8'd1;
            backlog_cnt[q] = '0;
            credit_cnt[q]  = 10'd1;
            done_flag[q]   = 1'b0;
        end
        rotation_cfg = 3'd4;
        rr_ptr       = QIDX_W'(NQ - 1);
        done_total   = '0;
    endtask

    task automatic close_queue(input int q);
        done_flag[q] = 1'b1;
        if (done_total != TOTAL_MAX) done_total = done_total + 1'b1;
    endtask

    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
        logic [WEIGHT_W-1:0] w;
        w = (val == '0) ? 8'd1 : val;
        if (idx < WEIGHT_REGS) begin
            weight_reg[idx[QIDX_W-1:0]] = w;
            credit_cnt[idx[QIDX_W-1:0]] = {2'b00, w};
        end else if (idx == CFG_QUEUES_IN_USE) begin
            rotation_cfg = val[QIU_W-1:0];
        end
    endtask

    // Advance the mirror by one item and queue the grant a select yields
    task automatic schedule_step(input logic [OP_W-1:0] op, input logic [QIDX_W-1:0] qidx);
        int n, p, i, q;
        grant_t g;
        if (op == OP_ENQUEUE) begin
            if (backlog_cnt[qidx] != '1) backlog_cnt[qidx] = backlog_cnt[qidx] + 1'b1;
        end else begin
            n = (rotation_cfg == 0) ? 1 : ((rotation_cfg > NQ) ? NQ : int'(rotation_cfg));
            p = (int'(rr_ptr) + 1) % n;
            i = 0;
            // Skip empty or finished queues, closing the empty ones
            while (i < n && (backlog_cnt[p] == '0 || done_flag[p])) begin
                if (!done_flag[p] && backlog_cnt[p] == '0) close_queue(p);
                p = (p + 1) % n;
                i++;
            end
            rr_ptr = QIDX_W'(p);
            if (credit_cnt[p] == 10'd1) close_queue(p);
            if (credit_cnt[p] != '0) credit_cnt[p] = credit_cnt[p] - 1'b1;
            // Reload the round once every queue in use is finished
            if (done_total >= n) begin
                done_total = '0;
                for (q = 0; q < NQ; q++) begin
                    credit_cnt[q] = {2'b00, weight_reg[q]};
                    done_flag[q]  = 1'b0;
                end
            end
            if (i == n) begin
                g.served = 1'b0;
                g.queue  = '0;
            end else begin
                if (backlog_cnt[p] != '0) backlog_cnt[p] = backlog_cnt[p] - 1'b1;
                g.served = 1'b1;
                g.queue  = QIDX_W'(p);
            end
            expected_grants.push_back(g);
        end
    endtask

    task automatic check_grant(input logic served, input logic [QIDX_W-1:0] queue);
        grant_t g;
        if (expected_grants.size() == 0) begin
            $display("%0t: grant beat with none expected, actual served %0d queue %0d",
                     $time, served, queue);
            error_count++;
        end else begin
            g = expected_grants.pop_front();
            if (served !== g.served) begin
                $display("%0t: served mismatch, expected %0d actual %0d",
                         $time, g.served, served);
                error_count++;
            end
            if (queue !== g.queue) begin
                $display("%0t: served_queue mismatch, expected %0d actual %0d",
                         $time, g.queue, queue);
                error_count++;
            end
        end
    endtask

    // Sample all three channels, update the mirror, check grants, watch for a hang
    always @(posedge i_clk) begin : monitor
        item_beat  <= i_rst_n && item_valid && item_ch.ready;
        grant_beat <= i_rst_n && grant_ch.valid && grant_ready;
        cfg_beat   <= i_rst_n && cfg_valid && cfg_ch.ready;
        if (!i_rst_n) begin
            reset_mirror();
            stall_cycles <= 0;
        end else begin
            if (item_valid && item_ch.ready) schedule_step(item_op, item_qidx);
            if (grant_ch.valid && grant_ready)
                check_grant(grant_ch.served, grant_ch.served_queue);
            if (cfg_valid && cfg_ch.ready) apply_reg_write(cfg_index, cfg_data);
            if ((item_valid && item_ch.ready) || (grant_ch.valid && grant_ready)
                    || (cfg_valid && cfg_ch.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Offer the next pending item once the current beat is taken
    always @(negedge i_clk) begin : item_driver
        sched_item_t nxt;
        if (i_rst_n && (!item_valid || item_beat)) begin
            if (item_gap > 0) begin
                item_gap   <= item_gap - 1;
                item_valid <= 1'b0;
            end else if (offered_items.size() > 0) begin
                nxt = offered_items.pop_front();
                item_valid <= 1'b1;
                item_op    <= nxt.op;
                item_qidx  <= nxt.qidx;
                item_gap   <= draw_gap();
            end else begin
                item_valid <= 1'b0;
            end
        end
    end

    // Grant receiver: random stalls, plus one long hold-off to back the block up
    always @(negedge i_clk) begin : grant_sink
        logic rdy;
        int g;
        rdy = 1'b1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rdy = 1'b0;
        end else if (pressure_armed && !pressure_done && item_valid) begin
            hold_left     <= HOLD_CYCLES - 1;
            pressure_done <= 1'b1;
            rdy = 1'b0;
        end else if (grant_gap > 0) begin
            grant_gap <= grant_gap - 1;
            rdy = 1'b0;
        end else if (grant_beat) begin
            g = draw_gap();
            if (g > 0) begin
                grant_gap <= g - 1;
                rdy = 1'b0;
            end
        end
        grant_ready <= rdy;
    end

    function automatic void offer(input logic [OP_W-1:0] op, input logic [QIDX_W-1:0] qidx);
        sched_item_t it;
        it.op   = op;
        it.qidx = qidx;
        offered_items.push_back(it);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        while (!cfg_beat) @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every item is taken and every grant is in, then let the block settle
    task automatic wait_idle();
        while (!(offered_items.size() == 0 && !item_valid && expected_grants.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_random_setting(output int rot_size);
        logic [CFG_DATA_W-1:0] w;
        logic [QIU_W-1:0] qn;
        int r, q;
        for (q = 0; q < WEIGHT_REGS; q++) begin
            r = $urandom_range(0, 9);
            if (r == 0) w = '0;
            else if (r == 1) w = 8'd255;
            else if (r < 6) w = CFG_DATA_W'($urandom_range(1, 4));
            else w = CFG_DATA_W'($urandom_range(1, 255));
            if ($urandom_range(0, 5) != 0) write_reg(CFG_WEIGHT0 + CFG_IDX_W'(q), w);
        end
        r = $urandom_range(0, 7);
        if (r == 0) qn = '0;
        else if (r == 1) qn = QIU_W'($urandom_range(5, 7));
        else qn = QIU_W'($urandom_range(1, 4));
        write_reg(CFG_QUEUES_IN_USE, {5'($urandom_range(0, 31)), qn});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)),
                      CFG_DATA_W'($urandom_range(0, 255)));
        rot_size = (qn == 0) ? 1 : ((qn > NQ) ? NQ : int'(qn));
    endtask

    // Enqueues mostly inside the rotation so that selects find work
    task automatic queue_random_traffic(input int count, input int enq_pct, input int rot_size);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < enq_pct) begin
                if ($urandom_range(0, 4) != 0)
                    offer(OP_ENQUEUE, QIDX_W'($urandom_range(0, rot_size - 1)));
                else
                    offer(OP_ENQUEUE, QIDX_W'($urandom_range(0, NQ - 1)));
            end else begin
                offer(OP_SELECT, QIDX_W'($urandom_range(0, NQ - 1)));
            end
        end
    endtask

    initial begin : stimulus
        int ph, q, k, rot;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset settings: select with nothing eligible, then fill and serve
        offer(OP_SELECT, 2'd0);
        for (q = 0; q < NQ; q++) offer(OP_ENQUEUE, QIDX_W'(q));
        offer(OP_ENQUEUE, 2'd3);
        for (k = 0; k < 6; k++) offer(OP_SELECT, QIDX_W'(k % NQ));
        wait_idle();

        // Directed: zero and full weights, short rotation, undecoded indexes
        write_reg(CFG_WEIGHT0, 8'd0);
        write_reg(CFG_WEIGHT1, 8'd255);
        write_reg(CFG_WEIGHT2, 8'd2);
        write_reg(CFG_WEIGHT3, 8'd3);
        write_reg(CFG_QUEUES_IN_USE, 8'd2);
        write_reg(CFG_SPARE_LO, 8'hA5);
        write_reg(CFG_SPARE_HI, 8'hFF);
        @(posedge i_clk);
        offer(OP_ENQUEUE, 2'd0);
        offer(OP_ENQUEUE, 2'd0);
        offer(OP_ENQUEUE, 2'd1);
        offer(OP_ENQUEUE, 2'd1);
        offer(OP_ENQUEUE, 2'd3);
        for (k = 0; k < 6; k++) offer(OP_SELECT, 2'd3);
        wait_idle();

        // Random phases, each under a setting of its own
        for (ph = 0; ph < 8; ph++) begin
            if (ph == 6) begin
                for (q = 0; q < WEIGHT_REGS; q++)
                    write_reg(CFG_WEIGHT0 + CFG_IDX_W'(q), 8'd255);
                write_reg(CFG_QUEUES_IN_USE, 8'd4);
                rot = NQ;
            end else if (ph == 7) begin
                for (q = 0; q < WEIGHT_REGS; q++)
                    write_reg(CFG_WEIGHT0 + CFG_IDX_W'(q), 8'd1);
                write_reg(CFG_QUEUES_IN_USE, 8'd1);
                rot = 1;
            end else begin
                program_random_setting(rot);
            end
            @(posedge i_clk);
            gaps_on        = (ph != 2);
            pressure_armed = (ph == 3);
            queue_random_traffic(PHASE_ITEMS, (ph == 5) ? 25 : $urandom_range(35, 70), rot);
            wait_idle();
        end

        // Pile packets onto one queue back to back, then serve from it
        write_reg(CFG_QUEUES_IN_USE, 8'd4);
        @(posedge i_clk);
        gaps_on = 1'b0;
        for (k = 0; k < TAIL_ENQUEUES; k++) offer(OP_ENQUEUE, 2'd1);
        for (k = 0; k < 20; k++) offer(OP_SELECT, 2'd0);
        wait_idle();

        if (error_count == 0 && expected_grants.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
